// File: hw/rtl/tsrc_pkg.sv
// types, constants and codes shared by the secure tag record checker
`default_nettype none
package tsrc_pkg;

  localparam int unsigned CNT_W = 5;

  localparam logic [CNT_W-1:0] REC_LEN       = CNT_W'(28);
  localparam logic [CNT_W-1:0] SUM_START     = CNT_W'(24);
  localparam logic [CNT_W-1:0] COUNT_MAX     = CNT_W'(31);
  localparam logic [CNT_W-1:0] SERIAL_FIRST  = CNT_W'(1);
  localparam logic [CNT_W-1:0] SERIAL_LAST   = CNT_W'(7);
  localparam logic [CNT_W-1:0] ISSUER_FIRST  = CNT_W'(8);
  localparam logic [CNT_W-1:0] ISSUER_LAST   = CNT_W'(11);
  localparam logic [CNT_W-1:0] ACCOUNT_FIRST = CNT_W'(12);
  localparam logic [CNT_W-1:0] ACCOUNT_LAST  = CNT_W'(19);

  localparam logic [31:0] ISSUER_LIMIT  = 32'd999999;
  localparam logic [63:0] ACCOUNT_LIMIT = 64'd9999999999999999;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_LENGTH   = 3'd1,
    ST_SERIAL   = 3'd2,
    ST_ISSUER   = 3'd3,
    ST_ACCOUNT  = 3'd4,
    ST_CHECKSUM = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [19:0] issuer_number;
    logic [53:0] account_number;
  } result_t;

endpackage
`default_nettype wire

// File: hw/rtl/tag_secure_record_checker.sv
// top level of the secure tag record checker: input stage, record logic, result register
//
//   channel   direction  handshake                  payload
//   item      in         item_valid / item_ready    tsrc_pkg::item_t
//   result    out        result_valid / result_ready tsrc_pkg::result_t
//   serial    in         serial_we                  serial_wdata[55:0]
//
// one byte per cycle sustained; a byte goes through the input register, then the
// record logic, and the status loads into the result register as the last byte
// leaves the input register; the result register decouples the sides: bytes keep
// flowing while a status waits, only a second last byte stalls until the waiting
// status is taken; synchronous rst clears the serial register and all record state
`default_nettype none
module tag_secure_record_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire tsrc_pkg::item_t    item,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output tsrc_pkg::result_t       result,
  input  wire logic               serial_we,
  input  wire logic [55:0]        serial_wdata
);
  import tsrc_pkg::*;

  logic [55:0] tag_serial;
  logic        stage_valid;
  item_t       stage;
  logic        advance;
  result_t     rec_result;

  assign advance    = stage_valid && (!stage.last_byte || !result_valid || result_ready);
  assign item_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_serial <= '0;
    end else if (serial_we) begin
      tag_serial <= serial_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      stage <= item;
    end
  end

  tsrc_record u_record (
    .clk        (clk),
    .rst        (rst),
    .take       (advance),
    .item       (stage),
    .tag_serial (tag_serial),
    .result     (rec_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && stage.last_byte) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage.last_byte) begin
      result <= rec_result;
    end
  end

  a_stall_on_full: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && stage.last_byte && result_valid && !result_ready) |-> !item_ready)
    else $error("last byte passed a waiting status");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status != ST_OK)) |->
      ((result.issuer_number == '0) && (result.account_number == '0)))
    else $error("failure status carries nonzero numbers");

  a_issuer_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status == ST_OK)) |->
      (result.issuer_number <= ISSUER_LIMIT[19:0]))
    else $error("ok status with issuer out of range");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (advance && stage.last_byte) |=> result_valid)
    else $error("status lost after last byte");

endmodule
`default_nettype wire

// File: hw/rtl/tsrc_record.sv
// per-record state: byte count, serial and checksum flags, number shifters, status decision
`default_nettype none
module tsrc_record (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 take,
  input  wire tsrc_pkg::item_t      item,
  input  wire logic [55:0]          tag_serial,
  output tsrc_pkg::result_t         result
);
  import tsrc_pkg::*;

  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic             serial_match, serial_match_next;
  logic [31:0]      issuer_shift, issuer_shift_next;
  logic [63:0]      account_shift, account_shift_next;
  logic [7:0]       column_xor [4];
  logic [7:0]       column_xor_next [4];
  logic             checksum_match, checksum_match_next;

  logic [2:0]       serial_sel;
  logic [7:0]       serial_want;
  logic             in_serial, in_sum, serial_ok, checksum_ok, length_ok;
  status_t          status;

  always_comb begin
    serial_sel  = 3'(SERIAL_LAST[2:0] - byte_count[2:0]);
    serial_want = 8'(tag_serial >> {serial_sel, 3'b000});
    in_serial   = (byte_count >= SERIAL_FIRST) && (byte_count <= SERIAL_LAST);
    in_sum      = (byte_count >= SUM_START) && (byte_count < REC_LEN);
    serial_ok   = serial_match && !(in_serial && (serial_want != item.data_byte));
    checksum_ok = checksum_match &&
                  !(in_sum && (column_xor[byte_count[1:0]] != item.data_byte));
    length_ok   = (byte_count == REC_LEN - CNT_W'(1));

    if (!length_ok) begin
      status = ST_LENGTH;
    end else if (!serial_ok) begin
      status = ST_SERIAL;
    end else if (issuer_shift > ISSUER_LIMIT) begin
      status = ST_ISSUER;
    end else if (account_shift > ACCOUNT_LIMIT) begin
      status = ST_ACCOUNT;
    end else if (!checksum_ok) begin
      status = ST_CHECKSUM;
    end else begin
      status = ST_OK;
    end

    result.status         = status;
    result.issuer_number  = (status == ST_OK) ? issuer_shift[19:0] : '0;
    result.account_number = (status == ST_OK) ? account_shift[53:0] : '0;
  end

  always_comb begin
    byte_count_next     = byte_count;
    serial_match_next   = serial_match;
    issuer_shift_next   = issuer_shift;
    account_shift_next  = account_shift;
    column_xor_next     = column_xor;
    checksum_match_next = checksum_match;
    if (take) begin
      if (item.last_byte) begin
        byte_count_next     = '0;
        serial_match_next   = 1'b1;
        issuer_shift_next   = '0;
        account_shift_next  = '0;
        column_xor_next     = '{default: 8'h00};
        checksum_match_next = 1'b1;
      end else begin
        if (byte_count != COUNT_MAX) begin
          byte_count_next = byte_count + CNT_W'(1);
        end
        serial_match_next   = serial_ok;
        checksum_match_next = checksum_ok;
        if ((byte_count >= ISSUER_FIRST) && (byte_count <= ISSUER_LAST)) begin
          issuer_shift_next = {item.data_byte, issuer_shift[31:8]};
        end
        if ((byte_count >= ACCOUNT_FIRST) && (byte_count <= ACCOUNT_LAST)) begin
          account_shift_next = {item.data_byte, account_shift[63:8]};
        end
        if (byte_count < SUM_START) begin
          column_xor_next[byte_count[1:0]] = column_xor[byte_count[1:0]] ^ item.data_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      serial_match   <= 1'b1;
      issuer_shift   <= '0;
      account_shift  <= '0;
      column_xor     <= '{default: 8'h00};
      checksum_match <= 1'b1;
    end else begin
      byte_count     <= byte_count_next;
      serial_match   <= serial_match_next;
      issuer_shift   <= issuer_shift_next;
      account_shift  <= account_shift_next;
      column_xor     <= column_xor_next;
      checksum_match <= checksum_match_next;
    end
  end

endmodule
`default_nettype wire

// File: test/tb.sv
// testbench for the secure tag record checker: directed and random records against a predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tsrc_pkg::*;

  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 6;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [55:0] SERIAL_ONES = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item_bus = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result_bus;
  logic serial_we = 1'b0;
  logic [55:0] serial_wdata = '0;

  // predictor state
  logic [55:0] serial_cfg;
  logic [4:0] rec_count;
  logic serial_ok;
  logic [31:0] issuer_acc;
  logic [63:0] account_acc;
  logic [7:0] col_sum [4];
  logic sum_ok;

  result_t expected_results [$];
  logic [7:0] rec_bytes [$];
  result_t want_res;
  int errors;
  int bytes_sent;
  int records_sent;
  int wait_cycles;
  int status_hits [6];
  bit idling;
  bit hold_req;

  tag_secure_record_checker i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_bus),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_bus),
    .serial_we    (serial_we),
    .serial_wdata (serial_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_record();
    rec_count = '0;
    serial_ok = 1'b1;
    issuer_acc = '0;
    account_acc = '0;
    col_sum = '{default: '0};
    sum_ok = 1'b1;
  endfunction

  function automatic void track_record_byte(logic [7:0] b, logic l);
    logic [4:0] pos;
    int sh;
    result_t r;
    pos = rec_count;
    if (pos < REC_LEN) begin
      if (pos >= SERIAL_FIRST && pos <= SERIAL_LAST) begin
        sh = 8 * (int'(SERIAL_LAST) - int'(pos));
        if (serial_cfg[sh +: 8] != b) serial_ok = 1'b0;
      end
      if (pos >= ISSUER_FIRST && pos <= ISSUER_LAST) issuer_acc = {b, issuer_acc[31:8]};
      if (pos >= ACCOUNT_FIRST && pos <= ACCOUNT_LAST) account_acc = {b, account_acc[63:8]};
      if (pos < SUM_START) col_sum[pos[1:0]] ^= b;
      else if (col_sum[pos[1:0]] != b) sum_ok = 1'b0;
    end
    if (rec_count < COUNT_MAX) rec_count++;
    if (l) begin
      r = '0;
      if (rec_count != REC_LEN) r.status = ST_LENGTH;
      else if (!serial_ok) r.status = ST_SERIAL;
      else if (issuer_acc > ISSUER_LIMIT) r.status = ST_ISSUER;
      else if (account_acc > ACCOUNT_LIMIT) r.status = ST_ACCOUNT;
      else if (!sum_ok) r.status = ST_CHECKSUM;
      else begin
        r.status = ST_OK;
        r.issuer_number = issuer_acc[19:0];
        r.account_number = account_acc[53:0];
      end
      expected_results.push_back(r);
      clear_record();
    end
  endfunction

  function automatic void build_record(logic [31:0] iss, logic [63:0] acct);
    logic [7:0] sums [4];
    sums = '{default: '0};
    rec_bytes.delete();
    rec_bytes.push_back(8'($urandom));
    for (int i = 1; i <= 7; i++) rec_bytes.push_back(serial_cfg[8 * (7 - i) +: 8]);
    for (int i = 0; i < 4; i++) rec_bytes.push_back(iss[8 * i +: 8]);
    for (int i = 0; i < 8; i++) rec_bytes.push_back(acct[8 * i +: 8]);
    repeat (4) rec_bytes.push_back(8'($urandom));
    for (int i = 0; i < 24; i++) sums[i % 4] ^= rec_bytes[i];
    for (int i = 0; i < 4; i++) rec_bytes.push_back(sums[i]);
  endfunction

  function automatic void build_noise(int len);
    rec_bytes.delete();
    repeat (len) rec_bytes.push_back(8'($urandom));
  endfunction

  function automatic logic [31:0] any_issuer(bit in_range);
    if (!in_range) return $urandom_range(32'hFFFF_FFFF, ISSUER_LIMIT + 1);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ISSUER_LIMIT;
      default: return $urandom_range(0, ISSUER_LIMIT);
    endcase
  endfunction

  function automatic logic [63:0] any_account(bit in_range);
    logic [63:0] a;
    a = {$urandom, $urandom};
    if (!in_range) return (a <= ACCOUNT_LIMIT) ? (a | 64'h8000_0000_0000_0000) : a;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ACCOUNT_LIMIT;
      default: return a % (ACCOUNT_LIMIT + 1);
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, field, got, want);
    errors++;
  endtask

  task automatic send_byte(logic [7:0] b, logic l);
    if (idling && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item_bus <= '{data_byte: b, last_byte: l};
    do @(posedge clk); while (!item_ready);
    track_record_byte(b, l);
    bytes_sent++;
  endtask

  task automatic send_record();
    foreach (rec_bytes[i]) send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
    records_sent++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_serial(logic [55:0] v);
    drain();
    serial_we <= 1'b1;
    serial_wdata <= v;
    @(posedge clk);
    serial_we <= 1'b0;
    serial_cfg = v;
  endtask

  task automatic test_field_ranges();
    build_record(0, 0);
    send_record();
    build_record(ISSUER_LIMIT, ACCOUNT_LIMIT);
    send_record();
    build_record(ISSUER_LIMIT + 1, 0);
    send_record();
    // issuer fault outranks account fault
    build_record('1, '1);
    send_record();
    build_record(0, ACCOUNT_LIMIT + 1);
    send_record();
    // account fault outranks checksum fault
    build_record(5, '1);
    rec_bytes[24] ^= 8'h01;
    send_record();
    build_record(1, 1);
    rec_bytes[27] ^= 8'h80;
    send_record();
    // serial fault outranks everything but length
    build_record('1, '1);
    rec_bytes[1] ^= 8'hff;
    send_record();
    build_record(any_issuer(1), any_account(1));
    rec_bytes[7] ^= 8'h01;
    send_record();
    drain();
  endtask

  task automatic test_lengths();
    build_noise(1);
    send_record();
    build_record(any_issuer(1), any_account(1));
    void'(rec_bytes.pop_back());
    send_record();
    build_record(any_issuer(1), any_account(1));
    rec_bytes.push_back(8'($urandom));
    send_record();
    // long enough for the byte count to saturate
    build_record(any_issuer(1), any_account(1));
    repeat (12) rec_bytes.push_back(8'($urandom));
    send_record();
    build_record(any_issuer(1), any_account(1));
    send_record();
    drain();
  endtask

  task automatic test_serial_settings();
    write_serial(SERIAL_ONES);
    build_record(any_issuer(1), any_account(1));
    send_record();
    build_record(any_issuer(1), any_account(1));
    rec_bytes[4] ^= 8'h10;
    send_record();
    write_serial(56'({$urandom, $urandom}));
    build_record(any_issuer(1), any_account(1));
    send_record();
    drain();
  endtask

  task automatic test_backpressure();
    idling = 1'b0;
    hold_req = 1'b1;
    repeat (16) begin
      build_noise($urandom_range(1, 3));
      send_record();
    end
    drain();
  endtask

  task automatic test_random_records(int n, bit allow_idle);
    int kind;
    repeat (n) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        build_record(any_issuer(1), any_account(1));
      end else if (kind < 70) begin
        build_record(any_issuer($urandom_range(0, 1)), any_account($urandom_range(0, 1)));
        if ($urandom_range(0, 1)) rec_bytes[$urandom_range(1, 7)] ^= 8'($urandom_range(1, 255));
        if ($urandom_range(0, 1)) rec_bytes[$urandom_range(24, 27)] ^= 8'($urandom_range(1, 255));
      end else if (kind < 80) begin
        build_record(any_issuer(1), any_account(1));
        repeat ($urandom_range(1, 27)) void'(rec_bytes.pop_back());
      end else if (kind < 88) begin
        build_record(any_issuer(1), any_account(1));
        repeat ($urandom_range(1, 12)) rec_bytes.push_back(8'($urandom));
      end else begin
        build_noise($urandom_range(1, 40));
      end
      idling = allow_idle && ($urandom_range(0, 3) != 0);
      send_record();
    end
    drain();
  endtask

  // result side: random stalls, plus one long hold when asked
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      result_ready <= 1'b1;
    end
  end

  // check each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", result_bus.status, '0);
      end else begin
        want_res = expected_results.pop_front();
        status_hits[want_res.status]++;
        if (result_bus.status !== want_res.status)
          report_mismatch("status", result_bus.status, want_res.status);
        if (result_bus.issuer_number !== want_res.issuer_number)
          report_mismatch("issuer_number", result_bus.issuer_number, want_res.issuer_number);
        if (result_bus.account_number !== want_res.account_number)
          report_mismatch("account_number", result_bus.account_number, want_res.account_number);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      wait_cycles <= 0;
    end else if (wait_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("** tag_secure_record_checker: FAILED **");
      $finish;
    end else begin
      wait_cycles <= wait_cycles + 1;
    end
  end

  initial begin
    serial_cfg = '0;
    clear_record();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idling = 1'b1;
    test_field_ranges();
    test_lengths();
    test_serial_settings();
    test_backpressure();
    write_serial(56'({$urandom, $urandom}));
    test_random_records(6, 1'b1);
    write_serial('0);
    test_random_records(5, 1'b1);
    write_serial(SERIAL_ONES);
    test_random_records(5, 1'b1);
    write_serial(56'({$urandom, $urandom}));
    test_random_records(6, 1'b0);
    $display("covered %0d bytes in %0d records over zero, all-ones and random serials",
             bytes_sent, records_sent);
    $display("statuses: ok %0d, length %0d, serial %0d, issuer %0d, account %0d, checksum %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4],
             status_hits[5]);
    if (errors == 0) begin
      $display("** tag_secure_record_checker: PASSED **");
    end else begin
      $display("** tag_secure_record_checker: FAILED **");
    end
    $finish;
  end

endmodule
